[src/srot_pkg.sv]
// Shared types and constants for the 32-bit shift and rotate unit.
package srot_pkg;

  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 5;                    // count bits that take effect
  localparam int RAW_CNT_W = 8;
  localparam int SHIFT_W  = 6;                    // funnel shift amount, 0..31
  localparam int WIN_W    = 2 * DATA_W + 1;       // {hi, lo, guard bit}
  localparam int TAP_W    = DATA_W + 2;           // {left carry, result, right carry}
  localparam int FINE_W   = 3;                    // low shift bits done in stage three
  localparam int COARSE_W = TAP_W + (1 << FINE_W) - 1;

  typedef enum logic [3:0] {
    CMD_SHLD = 4'd0,
    CMD_SHRD = 4'd1,
    CMD_ROL  = 4'd2,
    CMD_ROR  = 4'd3,
    CMD_RCL  = 4'd4,
    CMD_RCR  = 4'd5,
    CMD_SHL  = 4'd6,
    CMD_SHR  = 4'd7,
    CMD_SAR  = 4'd8
  } cmd_e;

  // Per-item control that rides along with the data
  typedef struct packed {
    logic act;    // masked count nonzero and a known command
    logic left;   // carry comes from the bit shifted out on the left
    logic szp;    // sign, zero and parity are updated
    logic sar;    // overflow forced low
    logic cin;    // incoming carry, passed through when inactive
  } ctl_t;

endpackage

[src/x86_shift_rotate_unit_32.sv]
// Top level of the pipelined 32-bit x86 shift and rotate unit.
//
// Commands enter on start with command, destination_value, source_value,
// count and carry_in. A command transfers at every rising edge where start
// is high and busy is low; busy stays low, so one command may enter every
// cycle. Only the low five bits of count take effect.
//
// Each command produces exactly one result, shown for one cycle with done
// high. Decode, coarse shift, fine shift and flag generation each hold a
// register stage, and the 64-bit funnel shift is split across the two
// shift stages. Throughput is one command per cycle.
//
// A masked count of zero, or an unknown command, returns the destination
// unchanged with writes_back low and carry_out equal to carry_in.
// Synchronous reset clears every valid bit in flight; results in the
// pipeline at reset are dropped. The receiver cannot stall the unit.
module x86_shift_rotate_unit_32
  import srot_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [3:0]           command,
  input  logic [DATA_W-1:0]    destination_value,
  input  logic [DATA_W-1:0]    source_value,
  input  logic [RAW_CNT_W-1:0] count,
  input  logic                 carry_in,
  output logic                 done,
  output logic [DATA_W-1:0]    result,
  output logic                 writes_back,
  output logic                 carry_out,
  output logic                 overflow_out,
  output logic                 szp_valid,
  output logic                 sign_out,
  output logic                 zero_out,
  output logic                 parity_out
);

  logic               dec_valid;
  ctl_t               dec_ctl;
  logic [DATA_W-1:0]  dec_hi;
  logic [DATA_W-1:0]  dec_lo;
  logic [SHIFT_W-1:0] dec_amount;
  logic               fun_valid;
  ctl_t               fun_ctl;
  logic [TAP_W-1:0]   fun_tap;

  // Fully pipelined: never hold off a command
  assign busy = 1'b0;

  srot_decode u_decode (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (start && !busy),
    .command           (command),
    .destination_value (destination_value),
    .source_value      (source_value),
    .count             (count),
    .carry_in          (carry_in),
    .valid             (dec_valid),
    .ctl               (dec_ctl),
    .hi                (dec_hi),
    .lo                (dec_lo),
    .amount            (dec_amount)
  );

  srot_funnel u_funnel (
    .clk      (clk),
    .rst      (rst),
    .in_valid (dec_valid),
    .in_ctl   (dec_ctl),
    .hi       (dec_hi),
    .lo       (dec_lo),
    .amount   (dec_amount),
    .valid    (fun_valid),
    .ctl      (fun_ctl),
    .tap      (fun_tap)
  );

  srot_flags u_flags (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (fun_valid),
    .in_ctl       (fun_ctl),
    .tap          (fun_tap),
    .done         (done),
    .result       (result),
    .writes_back  (writes_back),
    .carry_out    (carry_out),
    .overflow_out (overflow_out),
    .szp_valid    (szp_valid),
    .sign_out     (sign_out),
    .zero_out     (zero_out),
    .parity_out   (parity_out)
  );

`ifndef NO_ASSERTIONS
  // Every transfer in comes out on done once it has passed the register stages
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3) && !$past(rst, 4))
      |-> (done == $past(start, 4)))
    else $error("result strobe does not match command four cycles earlier");

  // Flag updates only happen on a write-back
  a_szp_needs_write: assert property (@(posedge clk) disable iff (rst)
    (done && (szp_valid || overflow_out)) |-> writes_back)
    else $error("flags updated without write-back");

  // A zero result is positive and has even parity
  a_zero_flags: assert property (@(posedge clk) disable iff (rst)
    (done && zero_out) |-> (parity_out && !sign_out && result == '0))
    else $error("zero flag inconsistent with result");

  // Skipped operations leave the carry untouched
  a_skip_carry: assert property (@(posedge clk) disable iff (rst)
    (done && !writes_back && !$past(rst, 4))
      |-> (carry_out == $past(carry_in, 4) && result == $past(destination_value, 4)))
    else $error("skipped operation changed carry or value");
`endif

endmodule

[src/srot_decode.sv]
// Stage one: map each command onto a 64-bit right funnel shift.
module srot_decode
  import srot_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [3:0]           command,
  input  logic [DATA_W-1:0]    destination_value,
  input  logic [DATA_W-1:0]    source_value,
  input  logic [RAW_CNT_W-1:0] count,
  input  logic                 carry_in,
  output logic                 valid,
  output ctl_t                 ctl,
  output logic [DATA_W-1:0]    hi,
  output logic [DATA_W-1:0]    lo,
  output logic [SHIFT_W-1:0]   amount
);

  logic [COUNT_W-1:0] n;
  logic [SHIFT_W-1:0] n_right;
  logic [SHIFT_W-1:0] n_left;
  logic [DATA_W-1:0]  d;
  ctl_t               ctl_next;
  logic [DATA_W-1:0]  hi_next;
  logic [DATA_W-1:0]  lo_next;
  logic [SHIFT_W-1:0] amount_next;

  assign n       = count[COUNT_W-1:0];
  assign d       = destination_value;
  assign n_right = {{(SHIFT_W-COUNT_W){1'b0}}, n};
  assign n_left  = SHIFT_W'(DATA_W) - n_right;

  // Pick the funnel halves and shift amount for each operation
  always_comb begin
    ctl_next     = '0;
    ctl_next.cin = carry_in;
    hi_next      = '0;
    lo_next      = d;
    amount_next  = '0;
    unique case (command)
      CMD_SHLD: begin
        hi_next = d; lo_next = source_value; amount_next = n_left;
        ctl_next.left = 1'b1; ctl_next.szp = 1'b1;
      end
      CMD_SHRD: begin
        hi_next = source_value; lo_next = d; amount_next = n_right;
        ctl_next.szp = 1'b1;
      end
      CMD_ROL: begin
        hi_next = d; lo_next = d; amount_next = n_left;
        ctl_next.left = 1'b1;
      end
      CMD_ROR: begin
        hi_next = d; lo_next = d; amount_next = n_right;
      end
      CMD_RCL: begin
        hi_next = d; lo_next = {carry_in, d[DATA_W-1:1]}; amount_next = n_left;
        ctl_next.left = 1'b1;
      end
      CMD_RCR: begin
        hi_next = {d[DATA_W-2:0], carry_in}; lo_next = d; amount_next = n_right;
      end
      CMD_SHL: begin
        hi_next = d; lo_next = '0; amount_next = n_left;
        ctl_next.left = 1'b1; ctl_next.szp = 1'b1;
      end
      CMD_SHR: begin
        hi_next = '0; lo_next = d; amount_next = n_right;
        ctl_next.szp = 1'b1;
      end
      CMD_SAR: begin
        hi_next = {DATA_W{d[DATA_W-1]}}; lo_next = d; amount_next = n_right;
        ctl_next.szp = 1'b1; ctl_next.sar = 1'b1;
      end
      default: begin
        hi_next = '0;
      end
    endcase
    ctl_next.act = (n != '0) && (command <= CMD_SAR);
    // Inactive items pass the destination through untouched
    if (!ctl_next.act) begin
      hi_next     = '0;
      lo_next     = d;
      amount_next = '0;
      ctl_next.szp = 1'b0;
      ctl_next.sar = 1'b0;
    end
  end

  // Advance the valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= in_valid;
    end
  end

  // Hold the decoded payload
  always_ff @(posedge clk) begin
    ctl    <= ctl_next;
    hi     <= hi_next;
    lo     <= lo_next;
    amount <= amount_next;
  end

endmodule

[src/srot_funnel.sv]
// Stages two and three: coarse then fine right shift of the funnel window.
module srot_funnel
  import srot_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  ctl_t               in_ctl,
  input  logic [DATA_W-1:0]  hi,
  input  logic [DATA_W-1:0]  lo,
  input  logic [SHIFT_W-1:0] amount,
  output logic               valid,
  output ctl_t               ctl,
  output logic [TAP_W-1:0]   tap
);

  logic [WIN_W-1:0]    window;
  logic [WIN_W-1:0]    coarse_full;
  logic [COARSE_W-1:0] coarse;
  logic [FINE_W-1:0]   fine;
  logic                mid_valid;
  ctl_t                mid_ctl;
  logic [COARSE_W-1:0] fine_full;

  // Shift by multiples of eight; guard bit below lo gives the right carry
  assign window      = {hi, lo, 1'b0};
  assign coarse_full = window >> {amount[SHIFT_W-1:FINE_W], {FINE_W{1'b0}}};
  assign fine_full   = coarse >> fine;

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      valid     <= 1'b0;
    end else begin
      mid_valid <= in_valid;
      valid     <= mid_valid;
    end
  end

  // Hold the coarse window, then the final tap
  always_ff @(posedge clk) begin
    coarse  <= coarse_full[COARSE_W-1:0];
    fine    <= amount[FINE_W-1:0];
    mid_ctl <= in_ctl;
    tap     <= fine_full[TAP_W-1:0];
    ctl     <= mid_ctl;
  end

endmodule

[src/srot_flags.sv]
// Stage four: result, carry, overflow and sign/zero/parity into output registers.
module srot_flags
  import srot_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  ctl_t              in_ctl,
  input  logic [TAP_W-1:0]  tap,
  output logic              done,
  output logic [DATA_W-1:0] result,
  output logic              writes_back,
  output logic              carry_out,
  output logic              overflow_out,
  output logic              szp_valid,
  output logic              sign_out,
  output logic              zero_out,
  output logic              parity_out
);

  logic [DATA_W-1:0] res;
  logic              cf;
  logic              of;

  assign res = tap[DATA_W:1];

  // Carry is the last bit out on the side the operation shifts toward, or carry_in when inactive
  always_comb begin
    if (!in_ctl.act) begin
      cf = in_ctl.cin;
    end else if (in_ctl.left) begin
      cf = tap[TAP_W-1];
    end else begin
      cf = tap[0];
    end
    if (!in_ctl.act || in_ctl.sar) begin
      of = 1'b0;
    end else if (in_ctl.left) begin
      of = cf ^ res[DATA_W-1];
    end else begin
      of = res[DATA_W-2] ^ res[DATA_W-1];
    end
  end

  // Advance the strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  // Hold the result fields
  always_ff @(posedge clk) begin
    result       <= res;
    writes_back  <= in_ctl.act;
    carry_out    <= cf;
    overflow_out <= of;
    szp_valid    <= in_ctl.szp;
    sign_out     <= in_ctl.szp & res[DATA_W-1];
    zero_out     <= in_ctl.szp & (res == '0);
    parity_out   <= in_ctl.szp & ~(^res[7:0]);
  end

endmodule
